### src/mkd_pkg.sv
// Package for the Morse key decoder: operation codes, result and config types,
// and the fixed letter and digit code table. No dependencies.
`default_nettype none

package mkd_pkg;

    localparam int MAX_SYMBOLS = 8;
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W       = $clog2(MAX_SYMBOLS);
    localparam int TABLE_LEN   = 5;

    localparam int CHAR_W = 7;
    localparam int TS_W   = 32;
    localparam int CFG_W  = 16;
    localparam int ADDR_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;

    localparam logic [CFG_W-1:0] DOT_LIMIT_RESET  = 16'd200;
    localparam logic [CFG_W-1:0] LETTER_GAP_RESET = 16'd600;
    localparam logic [CFG_W-1:0] WORD_GAP_RESET   = 16'd5000;

    localparam logic [ADDR_W-1:0] CFG_DOT_LIMIT  = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_LETTER_GAP = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_WORD_GAP   = 2'd2;

    typedef enum logic [1:0] {
        OP_CHECK   = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef struct packed {
        logic [CFG_W-1:0] dot_limit;
        logic [CFG_W-1:0] letter_gap;
        logic [CFG_W-1:0] word_gap;
    } cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    // Symbol i sits in bit i, a dash is a one.
    function automatic logic [CHAR_W-1:0] lookup_code(
        input logic [CNT_W-1:0] count,
        input logic [TABLE_LEN-1:0] bits
    );
        logic [CHAR_W-1:0] code;
        code = CHAR_UNKNOWN;
        if (count <= CNT_W'(TABLE_LEN)) begin
            unique case ({count[2:0], bits})
                {3'd2, 5'b00010}: code = 7'h41;
                {3'd4, 5'b00001}: code = 7'h42;
                {3'd4, 5'b00101}: code = 7'h43;
                {3'd3, 5'b00001}: code = 7'h44;
                {3'd1, 5'b00000}: code = 7'h45;
                {3'd4, 5'b00100}: code = 7'h46;
                {3'd3, 5'b00011}: code = 7'h47;
                {3'd4, 5'b00000}: code = 7'h48;
                {3'd2, 5'b00000}: code = 7'h49;
                {3'd4, 5'b01110}: code = 7'h4A;
                {3'd3, 5'b00101}: code = 7'h4B;
                {3'd4, 5'b00010}: code = 7'h4C;
                {3'd2, 5'b00011}: code = 7'h4D;
                {3'd2, 5'b00001}: code = 7'h4E;
                {3'd3, 5'b00111}: code = 7'h4F;
                {3'd4, 5'b00110}: code = 7'h50;
                {3'd4, 5'b01011}: code = 7'h51;
                {3'd3, 5'b00010}: code = 7'h52;
                {3'd3, 5'b00000}: code = 7'h53;
                {3'd1, 5'b00001}: code = 7'h54;
                {3'd3, 5'b00100}: code = 7'h55;
                {3'd4, 5'b01000}: code = 7'h56;
                {3'd3, 5'b00110}: code = 7'h57;
                {3'd4, 5'b01001}: code = 7'h58;
                {3'd4, 5'b01101}: code = 7'h59;
                {3'd4, 5'b00011}: code = 7'h5A;
                {3'd5, 5'b11111}: code = 7'h30;
                {3'd5, 5'b11110}: code = 7'h31;
                {3'd5, 5'b11100}: code = 7'h32;
                {3'd5, 5'b11000}: code = 7'h33;
                {3'd5, 5'b10000}: code = 7'h34;
                {3'd5, 5'b00000}: code = 7'h35;
                {3'd5, 5'b00001}: code = 7'h36;
                {3'd5, 5'b00011}: code = 7'h37;
                {3'd5, 5'b00111}: code = 7'h38;
                {3'd5, 5'b01111}: code = 7'h39;
                default:          code = CHAR_UNKNOWN;
            endcase
        end
        return code;
    endfunction

endpackage

`default_nettype wire

### src/morse_key_decoder_top.sv
// Top level of the Morse key decoder: config registers, input register,
// decode core and result queue. Depends on mkd_pkg, mkd_core, mkd_out_fifo.
//
//   Channel  Direction  Handshake           Payload
//   input    in         in_valid/in_stall   operation, timestamp_ms
//   output   out        out_valid/out_stall char_code, last
//   config   in         cfg_write           cfg_index, cfg_data
//
// A request is registered on acceptance and decoded from that register once the
// result queue has room for two, so one request can be taken every cycle while
// the queue has that room. Its results are written into the queue, whose head drives the output.
// A request that yields two results hands them out one at a time, through the
// queue's single read port. Reset clears all key state and loads the default timings.
// A stalled output fills the queue, and then in_stall rises while a request waits.
`default_nettype none

module morse_key_decoder_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    operation,
    input  wire logic [mkd_pkg::TS_W-1:0]      timestamp_ms,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mkd_pkg::CHAR_W-1:0]         char_code,
    output logic                               last,
    input  wire logic                          cfg_write,
    input  wire logic [mkd_pkg::ADDR_W-1:0]    cfg_index,
    input  wire logic [mkd_pkg::CFG_W-1:0]     cfg_data
);
    import mkd_pkg::*;

    cfg_t            cfg_reg;
    logic            stage_valid_reg;
    logic [1:0]      stage_op_reg;
    logic [TS_W-1:0] stage_ts_reg;

    logic  has_room;
    logic  fire;
    logic  accept;
    push_t push;
    res_t  head;

    assign fire     = stage_valid_reg && has_room;
    assign in_stall = stage_valid_reg && !has_room;
    assign accept   = in_valid && !in_stall;
    assign char_code = head.code;
    assign last      = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_limit  <= DOT_LIMIT_RESET;
            cfg_reg.letter_gap <= LETTER_GAP_RESET;
            cfg_reg.word_gap   <= WORD_GAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DOT_LIMIT:  cfg_reg.dot_limit  <= cfg_data;
                CFG_LETTER_GAP: cfg_reg.letter_gap <= cfg_data;
                CFG_WORD_GAP:   cfg_reg.word_gap   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_op_reg <= operation;
            stage_ts_reg <= timestamp_ms;
        end
    end

    mkd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .op    (stage_op_reg),
        .ts    (stage_ts_reg),
        .cfg   (cfg_reg),
        .push  (push)
    );

    mkd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_valid && !out_stall),
        .has_room  (has_room),
        .not_empty (out_valid),
        .head      (head)
    );

endmodule

`default_nettype wire

### src/mkd_core.sv
// Key timing state and decode decisions for one registered request.
// Depends on mkd_pkg for the config, result types and the code table.
`default_nettype none

module mkd_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fire,
    input  wire logic [1:0]                  op,
    input  wire logic [mkd_pkg::TS_W-1:0]    ts,
    input  wire mkd_pkg::cfg_t               cfg,
    output mkd_pkg::push_t                   push
);
    import mkd_pkg::*;

    logic [TS_W-1:0]        press_time_reg, press_time_next;
    logic [TS_W-1:0]        release_time_reg, release_time_next;
    logic                   have_release_reg, have_release_next;
    logic                   key_held_reg, key_held_next;
    logic [MAX_SYMBOLS-1:0] symbol_bits_reg, symbol_bits_next;
    logic [CNT_W-1:0]       symbol_count_reg, symbol_count_next;
    logic                   symbol_overflow_reg, symbol_overflow_next;
    logic                   space_done_reg, space_done_next;

    logic [TS_W-1:0]   dur;
    logic [TS_W-1:0]   idle;
    logic              letter;
    logic              space;
    logic [CHAR_W-1:0] letter_code;

    assign dur  = ts - press_time_reg;
    assign idle = ts - release_time_reg;

    always_comb
    begin
        letter_code = lookup_code(symbol_count_reg, symbol_bits_reg[TABLE_LEN-1:0]);
        if (symbol_overflow_reg)
        begin
            letter_code = CHAR_UNKNOWN;
        end
    end

    always_comb
    begin
        press_time_next      = press_time_reg;
        release_time_next    = release_time_reg;
        have_release_next    = have_release_reg;
        key_held_next        = key_held_reg;
        symbol_bits_next     = symbol_bits_reg;
        symbol_count_next    = symbol_count_reg;
        symbol_overflow_next = symbol_overflow_reg;
        space_done_next      = space_done_reg;
        letter               = 1'b0;
        space                = 1'b0;
        push                 = '0;

        if (fire)
        begin
            case (op)
                OP_PRESS:
                begin
                    press_time_next = ts;
                    key_held_next   = 1'b1;
                end
                OP_RELEASE:
                begin
                    if (symbol_count_reg < CNT_W'(MAX_SYMBOLS))
                    begin
                        if (dur >= TS_W'(cfg.dot_limit))
                        begin
                            symbol_bits_next[symbol_count_reg[IDX_W-1:0]] = 1'b1;
                        end
                        symbol_count_next = symbol_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        symbol_overflow_next = 1'b1;
                    end
                    release_time_next = ts;
                    have_release_next = 1'b1;
                    key_held_next     = 1'b0;
                    space_done_next   = 1'b0;
                end
                OP_CHECK:
                begin
                    if (!key_held_reg && have_release_reg)
                    begin
                        letter = (idle > TS_W'(cfg.letter_gap)) &&
                                 (symbol_count_reg != '0);
                        space  = (idle > TS_W'(cfg.word_gap)) &&
                                 (letter || (symbol_count_reg == '0 && !space_done_reg));
                        if (letter)
                        begin
                            symbol_bits_next     = '0;
                            symbol_count_next    = '0;
                            symbol_overflow_next = 1'b0;
                            space_done_next      = 1'b0;
                            release_time_next    = ts;
                        end
                        if (space)
                        begin
                            space_done_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (letter && space)
            begin
                push.count  = 2'd2;
                push.first  = '{code: letter_code, last: 1'b0};
                push.second = '{code: CHAR_SPACE, last: 1'b1};
            end
            else if (letter)
            begin
                push.count = 2'd1;
                push.first = '{code: letter_code, last: 1'b1};
            end
            else if (space)
            begin
                push.count = 2'd1;
                push.first = '{code: CHAR_SPACE, last: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_time_reg      <= '0;
            release_time_reg    <= '0;
            have_release_reg    <= 1'b0;
            key_held_reg        <= 1'b0;
            symbol_bits_reg     <= '0;
            symbol_count_reg    <= '0;
            symbol_overflow_reg <= 1'b0;
            space_done_reg      <= 1'b0;
        end
        else
        begin
            press_time_reg      <= press_time_next;
            release_time_reg    <= release_time_next;
            have_release_reg    <= have_release_next;
            key_held_reg        <= key_held_next;
            symbol_bits_reg     <= symbol_bits_next;
            symbol_count_reg    <= symbol_count_next;
            symbol_overflow_reg <= symbol_overflow_next;
            space_done_reg      <= space_done_next;
        end
    end

endmodule

`default_nettype wire

### src/mkd_out_fifo.sv
// Four-entry result queue that takes up to two results per cycle.
// Depends on mkd_pkg for the result and push types.
`default_nettype none

module mkd_out_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mkd_pkg::push_t  push,
    input  wire logic            pop,
    output logic                 has_room,
    output logic                 not_empty,
    output mkd_pkg::res_t        head
);
    import mkd_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    res_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [PTR_W-1:0] wr_ptr_plus;

    assign wr_ptr_plus = wr_ptr_reg + PTR_W'(1);
    assign not_empty   = (level_reg != '0);
    assign has_room    = (level_reg <= LVL_W'(DEPTH - 2));
    assign head        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + LVL_W'(push.count) - LVL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire
